FILE: design/dbdnr_pkg.sv
// ----------------------------------------------------------------------------
// dbdnr_pkg
// Shared types and constants for the digit-by-digit nth root block.
// ----------------------------------------------------------------------------
package dbdnr_pkg;

  // data widths
  localparam int WORD_W     = 64;
  localparam int RAD_W      = 31;
  // decimal digits of the widest radicand
  localparam int NUM_DIGITS = 10;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int LEN_W      = $clog2(NUM_DIGITS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0]  REG_ROOT_DEGREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_FRAC_DIGITS = 2'd1;
  localparam logic [CFG_DATA_W-1:0] ROOT_DEGREE_RST = 4'd2;
  localparam logic [CFG_DATA_W-1:0] FRAC_DIGITS_RST = 4'd3;

  // largest trial digit
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // decimal digits, index 0 is the least significant
  typedef logic [NUM_DIGITS-1:0][3:0] bcd_digits_t;

  // status of the shared multiplier
  typedef struct packed {
    logic done;
    logic ovf;
  } mul_status_t;

endpackage

FILE: design/dbdnr_bcd.sv
// ----------------------------------------------------------------------------
// dbdnr_bcd
// Binary to decimal converter, shift and add-3, one bit per cycle.
// ----------------------------------------------------------------------------
module dbdnr_bcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dbdnr_pkg::RAD_W-1:0]   value,
  output dbdnr_pkg::bcd_digits_t        digits,
  output logic                          done
);
  import dbdnr_pkg::*;

  localparam int CNT_W = $clog2(RAD_W + 1);

  logic [RAD_W-1:0] bin;
  logic [CNT_W-1:0] cnt;
  logic             running;
  bcd_digits_t      adj;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(RAD_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // shift register
  always_ff @(posedge clk) begin
    if (start) begin
      bin    <= value;
      digits <= '0;
    end else if (running) begin
      {digits, bin} <= {adj[NUM_DIGITS-1:0], bin} << 1;
    end
  end

endmodule

FILE: design/dbdnr_mul.sv
// ----------------------------------------------------------------------------
// dbdnr_mul
// 64 by 64 bit multiplier with overflow flag, built from one shared
// 32 by 32 bit multiplier used in two phases, then a final add.
// ----------------------------------------------------------------------------
module dbdnr_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dbdnr_pkg::WORD_W-1:0]  a,
  input  logic [dbdnr_pkg::WORD_W-1:0]  b,
  output logic [dbdnr_pkg::WORD_W-1:0]  product,
  output dbdnr_pkg::mul_status_t        status
);
  import dbdnr_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_MID  = 4'b0100,
    M_SUM  = 4'b1000
  } mul_state_t;

  mul_state_t        phase;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;
  logic [WORD_W-1:0] pp_lo;
  logic [WORD_W-1:0] pp_mid;
  logic              cross_ovf;
  logic              a_hi_nz;
  logic [31:0]       mx;
  logic [31:0]       my;
  logic [WORD_W-1:0] mp;
  logic [WORD_W:0]   sum;

  assign a_hi_nz = (opa[63:32] != '0);

  // shared multiplier: low product first, then the one cross product
  // that can be nonzero without a certain overflow
  always_comb begin
    if (phase == M_LO) begin
      mx = opa[31:0];
      my = opb[31:0];
    end else begin
      mx = a_hi_nz ? opa[63:32] : opb[63:32];
      my = a_hi_nz ? opb[31:0]  : opa[31:0];
    end
  end

  assign mp  = {32'b0, mx} * {32'b0, my};
  assign sum = {1'b0, pp_lo} + {1'b0, pp_mid[31:0], 32'b0};

  // sequencer and status
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= M_IDLE;
      status.done <= 1'b0;
    end else begin
      status.done <= 1'b0;
      case (phase)
        M_IDLE: if (start) phase <= M_LO;
        M_LO:   phase <= M_MID;
        M_MID:  phase <= M_SUM;
        M_SUM: begin
          phase       <= M_IDLE;
          status.done <= 1'b1;
          status.ovf  <= cross_ovf | (pp_mid[63:32] != '0) | sum[WORD_W];
        end
        default: phase <= M_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (phase)
      M_IDLE: begin
        if (start) begin
          opa <= a;
          opb <= b;
        end
      end
      M_LO: begin
        pp_lo     <= mp;
        cross_ovf <= a_hi_nz && (opb[63:32] != '0);
      end
      M_MID: pp_mid <= mp;
      M_SUM: product <= sum[WORD_W-1:0];
      default: ;
    endcase
  end

endmodule

FILE: design/digit_by_digit_nth_root.sv
// ----------------------------------------------------------------------------
// digit_by_digit_nth_root
// Decimal shifting nth root: floor of the nth root of radicand * 10^(n*k),
// one decimal digit of the root per group, with the final remainder.
//
//   channel  signals                                      direction
//   config   cfg_wr_en, cfg_index, cfg_data               in
//   command  start, radicand; busy                        in / out
//   result   done, root_scaled, remainder, overflow       out
//
// A word is taken when start is high and busy is low; busy stays high
// until the result, which shows for the single cycle in which done is high.
// Steps per word: the decimal conversion, alignment of the groups, then
// per group n digit feeds and, for each trial digit, a try and up to
// n-1 multiplies on the shared multiplier (stopped early once the power
// exceeds the prefix), and finally posting the result.
// Reset is synchronous; it restores n=2, k=3 and returns to idle.
// ----------------------------------------------------------------------------
module digit_by_digit_nth_root #(
  parameter int MAX_ROOT        = 8,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [dbdnr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbdnr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              start,
  input  logic [dbdnr_pkg::RAD_W-1:0]       radicand,
  output logic                              busy,
  output logic                              done,
  output logic [dbdnr_pkg::WORD_W-1:0]      root_scaled,
  output logic [dbdnr_pkg::WORD_W-1:0]      remainder,
  output logic                              overflow
);
  import dbdnr_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROOT + 1);
  localparam int KW    = $clog2(MAX_FRAC_DIGITS + 2);
  localparam int TOP_W = $clog2(NUM_DIGITS + MAX_ROOT);
  localparam int GRP_W = $clog2(NUM_DIGITS + MAX_FRAC_DIGITS + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CONV   = 8'b0000_0010,
    ST_ALIGN  = 8'b0000_0100,
    ST_GSTART = 8'b0000_1000,
    ST_FEED   = 8'b0001_0000,
    ST_TRY    = 8'b0010_0000,
    ST_MSTART = 8'b0100_0000,
    ST_MWAIT  = 8'b1000_0000
  } state_t;

  state_t                state;
  logic [CFG_DATA_W-1:0] root_degree;
  logic [CFG_DATA_W-1:0] frac_digits;
  logic [CNT_W-1:0]      n_eff;
  logic [KW-1:0]         k_eff;

  logic [TOP_W-1:0]      top;
  logic [TOP_W-1:0]      int_left;
  logic [TOP_W-1:0]      rd_idx;
  logic [GRP_W-1:0]      groups;
  logic [CNT_W-1:0]      feed_cnt;
  logic [CNT_W-1:0]      mul_left;
  logic [3:0]            d;
  logic [WORD_W-1:0]     t;
  logic [WORD_W-1:0]     y;
  logic [WORD_W-1:0]     y10;
  logic [WORD_W-1:0]     cand;
  logic [WORD_W-1:0]     acc;
  logic [WORD_W-1:0]     pw;

  bcd_digits_t           digits;
  logic                  bcd_done;
  logic [LEN_W-1:0]      len;
  logic [3:0]            feed_digit;
  logic [WORD_W+3:0]     t_wide;
  logic [WORD_W:0]       cand_sum;

  logic                  mul_start;
  logic [WORD_W-1:0]     mul_prod;
  mul_status_t           mst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_degree <= ROOT_DEGREE_RST;
      frac_digits <= FRAC_DIGITS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROOT_DEGREE: root_degree <= cfg_data;
        REG_FRAC_DIGITS: frac_digits <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp degree and digit count into range
  always_comb begin
    if (root_degree == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(root_degree) > MAX_ROOT) begin
      n_eff = CNT_W'(MAX_ROOT);
    end else begin
      n_eff = CNT_W'(root_degree);
    end
    if (int'(frac_digits) > MAX_FRAC_DIGITS) begin
      k_eff = KW'(MAX_FRAC_DIGITS);
    end else begin
      k_eff = KW'(frac_digits);
    end
  end

  // decimal digits of the radicand
  dbdnr_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (start && !busy),
    .value  (radicand),
    .digits (digits),
    .done   (bcd_done)
  );

  // shared multiplier for the trial powers
  dbdnr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (acc),
    .b       (cand),
    .product (mul_prod),
    .status  (mst)
  );

  assign mul_start = (state == ST_MSTART);
  assign busy      = (state != ST_IDLE);

  // number of significant decimal digits
  always_comb begin
    len = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) len = LEN_W'(i + 1);
    end
  end

  // next digit of the scaled radicand, zero past the integer digits
  assign rd_idx = int_left - 1'b1;
  always_comb begin
    feed_digit = 4'd0;
    if (int_left != '0 && rd_idx < TOP_W'(NUM_DIGITS)) begin
      feed_digit = digits[rd_idx[DIG_IDX_W-1:0]];
    end
  end

  // prefix times ten plus digit, carry bits mark overflow
  assign t_wide   = {1'b0, t, 3'b0} + {3'b0, t, 1'b0} + {{WORD_W{1'b0}}, feed_digit};
  assign cand_sum = {1'b0, y10} + {{(WORD_W-3){1'b0}}, d};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bcd_done) state <= ST_ALIGN;
        end
        ST_ALIGN: begin
          if (len == '0) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (top >= TOP_W'(len)) begin
            state <= ST_GSTART;
          end
        end
        ST_GSTART: begin
          if (groups == '0) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          if (t_wide[WORD_W+3:WORD_W] != '0) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (feed_cnt == CNT_W'(1)) begin
            state <= ST_TRY;
          end
        end
        ST_TRY: begin
          if (!cand_sum[WORD_W]) begin
            if (n_eff == CNT_W'(1)) begin
              if (cand_sum[WORD_W-1:0] <= t) state <= ST_GSTART;
            end else begin
              state <= ST_MSTART;
            end
          end
        end
        ST_MSTART: state <= ST_MWAIT;
        ST_MWAIT: begin
          if (mst.done) begin
            if (mst.ovf || mul_prod > t) begin
              state <= ST_TRY;
            end else if (mul_left == CNT_W'(1)) begin
              state <= ST_GSTART;
            end else begin
              state <= ST_MSTART;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        top    <= '0;
        groups <= '0;
        t      <= '0;
        y      <= '0;
        pw     <= '0;
      end
      ST_CONV: ;
      ST_ALIGN: begin
        if (len == '0) begin
          root_scaled <= '0;
          remainder   <= '0;
          overflow    <= 1'b0;
        end else if (top < TOP_W'(len)) begin
          // integer groups, the leading one padded with zeros
          top    <= top + TOP_W'(n_eff);
          groups <= groups + 1'b1;
        end else begin
          groups   <= groups + GRP_W'(k_eff);
          int_left <= top;
        end
      end
      ST_GSTART: begin
        if (groups == '0) begin
          root_scaled <= y;
          remainder   <= t - pw;
          overflow    <= 1'b0;
        end else begin
          y10      <= {y[WORD_W-4:0], 3'b0} + {y[WORD_W-2:0], 1'b0};
          feed_cnt <= n_eff;
          d        <= DIGIT_MAX;
        end
      end
      ST_FEED: begin
        if (t_wide[WORD_W+3:WORD_W] != '0) begin
          root_scaled <= '1;
          remainder   <= '1;
          overflow    <= 1'b1;
        end else begin
          t        <= t_wide[WORD_W-1:0];
          feed_cnt <= feed_cnt - 1'b1;
          if (int_left != '0) int_left <= int_left - 1'b1;
        end
      end
      ST_TRY: begin
        if (cand_sum[WORD_W]) begin
          d <= d - 1'b1;
        end else if (n_eff == CNT_W'(1)) begin
          if (cand_sum[WORD_W-1:0] <= t) begin
            y      <= cand_sum[WORD_W-1:0];
            pw     <= cand_sum[WORD_W-1:0];
            groups <= groups - 1'b1;
          end else begin
            d <= d - 1'b1;
          end
        end else begin
          cand     <= cand_sum[WORD_W-1:0];
          acc      <= cand_sum[WORD_W-1:0];
          mul_left <= n_eff - 1'b1;
        end
      end
      ST_MSTART: ;
      ST_MWAIT: begin
        if (mst.done) begin
          if (mst.ovf || mul_prod > t) begin
            d <= d - 1'b1;
          end else if (mul_left == CNT_W'(1)) begin
            y      <= cand;
            pw     <= mul_prod;
            groups <= groups - 1'b1;
          end else begin
            acc      <= mul_prod;
            mul_left <= mul_left - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the decimal digit-by-digit nth root block. A queue
// of planned words (radicands, register writes, drain points) feeds a
// clocked driver with bursts and random gaps. The driver predicts each root
// at acceptance, and a monitor compares every result field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import dbdnr_pkg::*;

  localparam int MAX_DEGREE     = 8;
  localparam int MAX_FRAC       = 9;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int PHASES         = 10;
  localparam int WORDS_PER_PHASE = 20;

  localparam logic [WORD_W-1:0] WORD_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [RAD_W-1:0]  RAD_MAX  = 31'h7FFF_FFFF;
  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {ITEM_WORD, ITEM_REG_WRITE, ITEM_DRAIN} item_kind_e;

  typedef struct {
    item_kind_e             kind;
    logic [RAD_W-1:0]       value;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
  } plan_item_t;

  typedef struct {
    logic [WORD_W-1:0] root;
    logic [WORD_W-1:0] rem;
    logic              ovf;
    logic [4:0]        groups;
  } root_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic [RAD_W-1:0] radicand = '0;
  logic busy;
  logic done;
  logic [WORD_W-1:0] root_scaled;
  logic [WORD_W-1:0] remainder;
  logic overflow;

  plan_item_t   stim_plan[$];
  root_result_t roots_due[$];

  // predictor copy of configuration and state
  logic [CFG_DATA_W-1:0] model_degree = ROOT_DEGREE_RST;
  logic [CFG_DATA_W-1:0] model_frac   = FRAC_DIGITS_RST;
  logic [WORD_W-1:0]     model_root   = '0;
  logic [WORD_W-1:0]     model_rem    = '0;
  logic [4:0]            model_groups = '0;

  // settings as planned while the stimulus is built
  logic [CFG_DATA_W-1:0] plan_degree = ROOT_DEGREE_RST;
  logic [CFG_DATA_W-1:0] plan_frac   = FRAC_DIGITS_RST;

  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int overflow_seen = 0;
  int exact_seen = 0;
  int reg_writes = 0;
  int stall_cycles = 0;

  digit_by_digit_nth_root #(
    .MAX_ROOT       (MAX_DEGREE),
    .MAX_FRAC_DIGITS(MAX_FRAC)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start      (start),
    .radicand   (radicand),
    .busy       (busy),
    .done       (done),
    .root_scaled(root_scaled),
    .remainder  (remainder),
    .overflow   (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clamp of the degree register as the block applies it
  function automatic int unsigned effective_degree(input logic [CFG_DATA_W-1:0] deg);
    if (deg == 0) return 1;
    if (deg > MAX_DEGREE) return MAX_DEGREE;
    return deg;
  endfunction

  function automatic int unsigned effective_frac(input logic [CFG_DATA_W-1:0] fr);
    return (fr > MAX_FRAC) ? MAX_FRAC : fr;
  endfunction

  // base^e, flagged when it does not fit in a word
  function automatic bit power_fits(input logic [WORD_W-1:0] base, input int unsigned e,
                                    output logic [WORD_W-1:0] res);
    logic [WORD_W-1:0] acc;
    bit ok;
    int unsigned i;
    acc = 64'd1;
    ok = 1'b1;
    for (i = 0; i < e; i++) begin
      if (ok && base != 0 && acc > WORD_MAX / base) ok = 1'b0;
      else if (ok) acc = acc * base;
    end
    res = ok ? acc : 64'd0;
    return ok;
  endfunction

  // floor nth root of a * 10^(n*k), one decimal digit per group
  function automatic root_result_t nth_root_of(input logic [RAD_W-1:0] a,
                                               input logic [CFG_DATA_W-1:0] deg,
                                               input logic [CFG_DATA_W-1:0] fr);
    root_result_t r;
    int unsigned n, k, i, len, groups, g, shift;
    int d, best;
    bit ovf, found;
    logic [WORD_W-1:0] s, y, t, p, div, y10, pw;
    n = effective_degree(deg);
    k = effective_frac(fr);
    s = a;
    ovf = 1'b0;
    for (i = 0; i < n * k; i++) begin
      if (!ovf) begin
        if (s > WORD_MAX / 10) ovf = 1'b1;
        else s = s * 10;
      end
    end
    if (ovf) begin
      r.root = WORD_MAX;
      r.rem = WORD_MAX;
      r.ovf = 1'b1;
      r.groups = '0;
      return r;
    end
    len = 0;
    p = a;
    while (p != 0) begin
      p = p / 10;
      len++;
    end
    groups = (a == 0) ? 0 : ((len + n - 1) / n + k);
    y = '0;
    t = '0;
    for (g = 0; g < groups; g++) begin
      shift = n * (groups - 1 - g);
      div = 64'd1;
      for (i = 0; i < shift; i++) div = div * 10;
      t = s / div;
      y10 = y * 10;
      best = 0;
      found = 1'b0;
      // largest digit whose trial power still fits the prefix
      for (d = 9; d >= 1; d--) begin
        if (!found && y10 <= WORD_MAX - d) begin
          if (power_fits(y10 + d, n, pw) && pw <= t) begin
            best = d;
            found = 1'b1;
          end
        end
      end
      y = y10 + best;
    end
    if (groups == 0) begin
      y = '0;
      t = '0;
    end
    void'(power_fits(y, n, pw));
    r.root = y;
    r.rem = t - pw;
    r.ovf = 1'b0;
    r.groups = groups[4:0];
    return r;
  endfunction

  // largest radicand whose scaled value still fits a word
  function automatic logic [WORD_W-1:0] radicand_bound(input logic [CFG_DATA_W-1:0] deg,
                                                       input logic [CFG_DATA_W-1:0] fr);
    logic [WORD_W-1:0] b;
    int unsigned i;
    b = WORD_MAX;
    for (i = 0; i < effective_degree(deg) * effective_frac(fr); i++) b = b / 10;
    return (b > RAD_MAX) ? RAD_MAX : b;
  endfunction

  // mostly radicands that fit, with full-range noise, small values and exact powers
  function automatic logic [RAD_W-1:0] pick_radicand(input logic [CFG_DATA_W-1:0] deg,
                                                     input logic [CFG_DATA_W-1:0] fr);
    logic [WORD_W-1:0] bound, span, v, pw;
    int unsigned sel, digits, i;
    bound = radicand_bound(deg, fr);
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      digits = $urandom_range(1, 10);
      span = 64'd1;
      for (i = 0; i < digits; i++) span = span * 10;
      v = {$urandom, $urandom} % span;
      if (v > bound) v = v % (bound + 1);
    end else if (sel < 7) begin
      v = {32'd0, $urandom} & RAD_MAX;
    end else if (sel < 8) begin
      v = $urandom_range(0, 99);
    end else begin
      v = $urandom_range(0, 60);
      if (power_fits(v, effective_degree(deg), pw) && pw <= bound) v = pw;
    end
    return v[RAD_W-1:0];
  endfunction

  task automatic plan_word(input logic [RAD_W-1:0] value);
    plan_item_t it;
    it = '{kind: ITEM_WORD, value: value, reg_index: '0, reg_data: '0};
    stim_plan.push_back(it);
  endtask

  task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    plan_item_t it;
    it = '{kind: ITEM_REG_WRITE, value: '0, reg_index: idx, reg_data: data};
    stim_plan.push_back(it);
    if (idx == REG_ROOT_DEGREE) plan_degree = data;
    else if (idx == REG_FRAC_DIGITS) plan_frac = data;
  endtask

  task automatic plan_drain();
    plan_item_t it;
    it = '{kind: ITEM_DRAIN, value: '0, reg_index: '0, reg_data: '0};
    stim_plan.push_back(it);
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // driver: words in bursts, register writes and drains only once idle
  always @(posedge clk) begin : drive_proc
    int burst_left;
    int gap_left;
    bit gap_on_busy;
    int idle_run;
    logic drive_start;
    logic drive_wr;
    root_result_t want;
    drive_start = 1'b0;
    drive_wr = 1'b0;
    if (rst) begin
      burst_left = 0;
      gap_left = $urandom_range(0, 10);
      gap_on_busy = 1'b0;
      idle_run = 0;
      start <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      // word taken at this edge
      if (start && !busy) begin
        want = nth_root_of(stim_plan[0].value, model_degree, model_frac);
        roots_due.push_back(want);
        model_root = want.root;
        model_rem = want.rem;
        model_groups = want.groups;
        void'(stim_plan.pop_front());
        words_sent++;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(0, 7);
          gap_left = $urandom_range(1, 40);
          gap_on_busy = $urandom_range(0, 1);
        end
      end
      // register write taken at this edge
      if (cfg_wr_en) begin
        if (cfg_index == REG_ROOT_DEGREE) model_degree = cfg_data;
        else if (cfg_index == REG_FRAC_DIGITS) model_frac = cfg_data;
        void'(stim_plan.pop_front());
        reg_writes++;
      end
      if (!start && !busy && !done) idle_run++;
      else idle_run = 0;
      if (stim_plan.size() != 0) begin
        case (stim_plan[0].kind)
          ITEM_WORD: begin
            if (start && busy) begin
              drive_start = 1'b1;
            end else if (gap_left == 0) begin
              drive_start = 1'b1;
              radicand <= stim_plan[0].value;
            end else if (!busy || gap_on_busy) begin
              gap_left--;
            end
          end
          ITEM_REG_WRITE: begin
            if (idle_run >= SETTLE_CYCLES && roots_due.size() == 0) begin
              drive_wr = 1'b1;
              cfg_index <= stim_plan[0].reg_index;
              cfg_data <= stim_plan[0].reg_data;
            end
          end
          ITEM_DRAIN: begin
            if (idle_run >= 1 && roots_due.size() == 0) void'(stim_plan.pop_front());
          end
          default: ;
        endcase
      end
      start <= drive_start;
      cfg_wr_en <= drive_wr;
    end
  end

  // monitor: every result against the oldest prediction
  always @(posedge clk) begin : check_proc
    root_result_t want;
    if (!rst && done) begin
      if (roots_due.size() == 0) begin
        report_mismatch("result with none pending, root", root_scaled, '0);
      end else begin
        want = roots_due.pop_front();
        if (root_scaled !== want.root) report_mismatch("root_scaled", root_scaled, want.root);
        if (remainder !== want.rem) report_mismatch("remainder", remainder, want.rem);
        if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
        results_seen++;
        if (want.ovf) overflow_seen++;
        else if (want.rem == 0) exact_seen++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int j;
    logic [CFG_DATA_W-1:0] deg;
    logic [CFG_DATA_W-1:0] fr;
    // reset settings: zero, one, widest radicand and two
    plan_word('0);
    plan_word(31'd1);
    plan_word(RAD_MAX);
    plan_word(31'd2);
    // plain integer root of degree one
    plan_reg(REG_ROOT_DEGREE, 4'd1);
    plan_reg(REG_FRAC_DIGITS, 4'd0);
    plan_word(RAD_MAX);
    plan_word(31'd1000000000);
    plan_word(31'd7);
    // top settings: zero radicand, then scaled value too wide
    plan_reg(REG_ROOT_DEGREE, 4'd8);
    plan_reg(REG_FRAC_DIGITS, 4'd9);
    plan_word('0);
    plan_word(31'd1);
    plan_word(RAD_MAX);
    // degree zero taken as one, digits above the limit clamped
    plan_reg(REG_ROOT_DEGREE, 4'd0);
    plan_reg(REG_FRAC_DIGITS, 4'd15);
    plan_word(RAD_MAX);
    plan_word(31'h2AAA_AAAA);
    // degree above the limit clamped; writes to unused indexes ignored
    plan_reg(REG_ROOT_DEGREE, 4'd15);
    plan_reg(REG_FRAC_DIGITS, 4'd0);
    plan_reg(REG_SPARE_A, 4'd3);
    plan_reg(REG_SPARE_B, 4'd15);
    plan_word(RAD_MAX);
    plan_word(31'd255);
    // cube root with an exact cube and two values that overflow
    plan_reg(REG_ROOT_DEGREE, 4'd3);
    plan_reg(REG_FRAC_DIGITS, 4'd4);
    plan_word(31'd1000);
    plan_word(31'd123456789);
    plan_word(31'h5555_5555);
    // random phases, each with fresh settings
    for (phase = 0; phase < PHASES; phase++) begin
      deg = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
      fr = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 15));
      if ($urandom_range(0, 1)) begin
        plan_reg(REG_ROOT_DEGREE, deg);
        plan_reg(REG_FRAC_DIGITS, fr);
      end else begin
        plan_reg(REG_FRAC_DIGITS, fr);
        plan_reg(REG_ROOT_DEGREE, deg);
      end
      if ($urandom_range(0, 3) == 0)
        plan_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 4'($urandom_range(0, 15)));
      for (j = 0; j < WORDS_PER_PHASE; j++) begin
        if (phase % 3 == 1 && j == WORDS_PER_PHASE / 2) plan_drain();
        plan_word(pick_radicand(plan_degree, plan_frac));
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (stim_plan.size() != 0 || roots_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d words over %0d register writes: %0d overflowed, %0d exact roots",
             words_sent, reg_writes, overflow_seen, exact_seen);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dbdnr_pkg.sv
design/dbdnr_bcd.sv
design/dbdnr_mul.sv
design/digit_by_digit_nth_root.sv
tb/testbench.sv
